[design/dpra_pkg.sv]
// Shared constants and types of the pulse rate averager.
// Used by every module of the block; depends on nothing else.
package dpra_pkg;

    localparam int HISTORY_DEPTH  = 20;
    localparam int SLOT_W         = $clog2(HISTORY_DEPTH);
    localparam int INTERVAL_W     = 16;
    localparam int TICK_W         = 16;
    localparam int PERIOD_W       = 10;
    localparam int RATE_W         = 16;
    localparam int TOTAL_W        = INTERVAL_W + SLOT_W;
    localparam int IN_DATA_W      = 8;
    localparam int RATE_NUMERATOR = 60000;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(50);

    // The mean is the total times a rounded-up reciprocal of the depth. The extra
    // fraction bits keep the truncated product exact over the whole range of the total.
    localparam int MEAN_SHIFT   = TOTAL_W + SLOT_W;
    localparam int MEAN_RECIP_W = TOTAL_W + 1;
    localparam int MEAN_PROD_W  = TOTAL_W + MEAN_RECIP_W;
    localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP =
        MEAN_RECIP_W'(((1 << MEAN_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

    // The queue depth must be a power of two so that the pointers wrap by themselves.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                  beat;
        logic [INTERVAL_W-1:0] interval;
    } dpra_item_t;

    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] dividend;
        logic [TOTAL_W-1:0] divisor;
    } dpra_div_req_t;

    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] quotient;
    } dpra_div_rsp_t;

endpackage

[design/digital_pulse_rate_averager_core.sv]
// Top level of the pulse rate averager: front end, tick queue and back end.
// Depends on dpra_pkg, dpra_front, dpra_queue and dpra_back.
//
// Each input beat is one sample tick of the beat line and gives exactly one result beat
// carrying the held rate in beats per minute and a flag for a rising edge. The front end
// takes a tick in every cycle while its two-entry queue has room. A tick without an edge
// passes straight to the result register. A tick with an edge passes the back end states
// read, sum, mean and rate, in which the serial divider divides 60000 by the mean
// interval; the mean itself comes from one multiplication by the reciprocal of the depth.
// When the mean is zero the divider is skipped. A stalled result register holds the back
// end until it is free. The interval history is cleared at reset through one valid bit
// per entry, so no clearing pass is needed.
module digital_pulse_rate_averager_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dpra_pkg::PERIOD_W-1:0]   cfg_wr_data,  // sample_period_ms
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dpra_pkg::IN_DATA_W-1:0]  s_tdata,      // [0] pulse_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dpra_pkg::RATE_W-1:0]     m_tdata,      // [15:0] rate_bpm
    output logic                            m_tuser       // [0] beat_seen
);
    import dpra_pkg::*;

    logic       push;
    dpra_item_t push_item;
    logic       q_full;
    logic       q_valid;
    dpra_item_t q_item;
    logic       q_pop;

    dpra_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    dpra_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    dpra_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[design/dpra_front.sv]
// Front end: takes sample ticks, detects rising edges and forms beat intervals.
// Holds the sample period register. Depends on dpra_pkg.
module dpra_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [dpra_pkg::PERIOD_W-1:0] cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dpra_pkg::IN_DATA_W-1:0] s_tdata,   // [0] pulse_in
    input  logic                         q_full,
    output logic                         push,
    output dpra_pkg::dpra_item_t         push_item
);
    import dpra_pkg::*;

    localparam int PROD_W = TICK_W + PERIOD_W;

    logic [PERIOD_W-1:0] period_reg;
    logic                last_level_reg;
    logic [TICK_W-1:0]   tick_count_reg;
    logic [TICK_W-1:0]   tick_inc;
    logic [PROD_W-1:0]   product;
    logic                level;
    logic                rise;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign level    = s_tdata[0];
    assign rise     = level && !last_level_reg;

    always_comb begin
        tick_inc = (tick_count_reg == '1) ? tick_count_reg : tick_count_reg + TICK_W'(1);
        product  = PROD_W'(tick_inc) * PROD_W'(period_reg);
        push_item.beat = rise;
        if (|product[PROD_W-1:INTERVAL_W]) begin
            push_item.interval = '1;
        end else begin
            push_item.interval = product[INTERVAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= PERIOD_RESET;
            last_level_reg <= 1'b0;
            tick_count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (push) begin
                last_level_reg <= level;
                tick_count_reg <= rise ? '0 : tick_inc;
            end
        end
    end

endmodule

[design/dpra_queue.sv]
// Short queue of classified ticks between the front end and the back end.
// Depends on dpra_pkg.
module dpra_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  dpra_pkg::dpra_item_t push_item,
    output logic                 full,
    output logic                 q_valid,
    output dpra_pkg::dpra_item_t q_item,
    input  logic                 pop
);
    import dpra_pkg::*;

    dpra_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

[design/dpra_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Used for the rate calculation. Depends on dpra_pkg.
module dpra_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dpra_pkg::dpra_div_req_t req,
    output dpra_pkg::dpra_div_rsp_t rsp
);
    import dpra_pkg::*;

    localparam int CNT_W = $clog2(TOTAL_W + 1);

    logic [TOTAL_W-1:0] rem_reg;
    logic [TOTAL_W-1:0] quot_reg;
    logic [TOTAL_W-1:0] divisor_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [TOTAL_W:0]   partial;
    logic [TOTAL_W:0]   trial;

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

    always_comb begin
        partial = {rem_reg, quot_reg[TOTAL_W-1]};
        trial   = partial - {1'b0, divisor_reg};
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= '0;
            quot_reg    <= req.dividend;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            // A clear top bit of the trial means the divisor fitted.
            if (!trial[TOTAL_W]) begin
                rem_reg  <= trial[TOTAL_W-1:0];
                quot_reg <= {quot_reg[TOTAL_W-2:0], 1'b1};
            end else begin
                rem_reg  <= partial[TOTAL_W-1:0];
                quot_reg <= {quot_reg[TOTAL_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                count_reg <= CNT_W'(TOTAL_W);
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[design/dpra_back.sv]
// Back end: updates the interval history on a beat, derives the rate and
// drives the result register. Depends on dpra_pkg and dpra_div.
module dpra_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  dpra_pkg::dpra_item_t          q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpra_pkg::RATE_W-1:0]   m_tdata,   // [15:0] rate_bpm
    output logic                          m_tuser    // [0] beat_seen
);
    import dpra_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b000_0001,
        ST_READ      = 7'b000_0010,
        ST_SUM       = 7'b000_0100,
        ST_MEAN      = 7'b000_1000,
        ST_RATE_GO   = 7'b001_0000,
        ST_RATE_WAIT = 7'b010_0000,
        ST_EMIT      = 7'b100_0000
    } dpra_state_t;

    dpra_state_t           state_reg, state_next;
    dpra_item_t            item_reg, item_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [INTERVAL_W-1:0] mean_reg, mean_next;
    logic [RATE_W-1:0]     held_reg, held_next;
    logic                  out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]     out_rate_reg, out_rate_next;
    logic                  out_beat_reg, out_beat_next;

    logic [INTERVAL_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hist_valid_reg;
    logic [INTERVAL_W-1:0] old_raw_reg;
    logic                  old_hit_reg;
    logic [INTERVAL_W-1:0] old_interval;
    logic [MEAN_PROD_W-1:0] mean_prod;

    dpra_div_req_t div_req;
    dpra_div_rsp_t div_rsp;
    logic          out_free;

    dpra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign out_free     = !out_valid_reg || m_tready;
    assign old_interval = old_hit_reg ? old_raw_reg : '0;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_rate_reg;
    assign m_tuser      = out_beat_reg;
    assign mean_prod    = MEAN_PROD_W'(total_reg) * MEAN_PROD_W'(MEAN_RECIP);

    // Read of the oldest slot and write of the new interval share one edge;
    // the read returns the value from before the write.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            old_raw_reg        <= hist_mem[slot_reg];
            old_hit_reg        <= hist_valid_reg[slot_reg];
            hist_mem[slot_reg] <= item_reg.interval;
        end
    end

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        total_next     = total_reg;
        slot_next      = slot_reg;
        mean_next      = mean_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_rate_next  = out_rate_reg;
        out_beat_next  = out_beat_reg;
        q_pop          = 1'b0;
        div_req        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.beat) begin
                        q_pop      = 1'b1;
                        item_next  = q_item;
                        state_next = ST_READ;
                    end else if (out_free) begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_rate_next  = held_reg;
                        out_beat_next  = 1'b0;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                total_next = total_reg - TOTAL_W'(old_interval)
                           + TOTAL_W'(item_reg.interval);
                if (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) begin
                    slot_next = '0;
                end else begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
                state_next = ST_MEAN;
            end
            ST_MEAN: begin
                mean_next  = mean_prod[MEAN_SHIFT +: INTERVAL_W];
                state_next = ST_RATE_GO;
            end
            ST_RATE_GO: begin
                if (mean_reg == '0) begin
                    held_next  = RATE_W'(RATE_NUMERATOR);
                    state_next = ST_EMIT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = TOTAL_W'(RATE_NUMERATOR);
                    div_req.divisor  = TOTAL_W'(mean_reg);
                    state_next       = ST_RATE_WAIT;
                end
            end
            ST_RATE_WAIT: begin
                if (div_rsp.done) begin
                    held_next  = div_rsp.quotient[RATE_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_rate_next  = held_reg;
                    out_beat_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        mean_reg     <= mean_next;
        out_rate_reg <= out_rate_next;
        out_beat_reg <= out_beat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            total_reg      <= '0;
            slot_reg       <= '0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
            hist_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            slot_reg      <= slot_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_READ) begin
                hist_valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

endmodule

[design/dpra_checker.sv]
// Port-level checks of the pulse rate averager, bound to the top level.
// Depends on dpra_pkg and digital_pulse_rate_averager_core.
module dpra_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dpra_pkg::RATE_W-1:0]   m_tdata,
    input logic                          m_tuser
);
    import dpra_pkg::*;

    logic [RATE_W-1:0] last_rate_reg;

    // The rate of the most recently delivered result beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_rate_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            last_rate_reg <= m_tdata;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_rate_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= RATE_W'(RATE_NUMERATOR))
        else $error("rate above its ceiling");

    a_rate_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == last_rate_reg)
        else $error("rate changed without a beat");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind digital_pulse_rate_averager_core dpra_checker u_checker (.*);

[tb/tb.sv]
// Self-checking testbench for digital_pulse_rate_averager_core: drives sample ticks
// and checks every rate beat against a built-in model of the averager.
// Depends on dpra_pkg and the core RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpra_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_TICKS  = 310;

    typedef struct packed {
        logic [RATE_W-1:0] rate_bpm;
        logic              beat_seen;
    } rate_result_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [PERIOD_W-1:0]  cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [RATE_W-1:0]    m_tdata;
    logic                 m_tuser;

    digital_pulse_rate_averager_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus and expectations.
    bit           tick_levels_q[$];
    rate_result_t rate_expect_q[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;

    // Own copy of the averager state.
    logic [PERIOD_W-1:0]   period_ms;
    logic                  prev_level;
    logic [TICK_W-1:0]     ticks_since_beat;
    logic [INTERVAL_W-1:0] interval_hist [HISTORY_DEPTH];
    logic [SLOT_W-1:0]     oldest_slot;
    logic [TOTAL_W-1:0]    interval_sum;
    logic [RATE_W-1:0]     held_bpm;

    initial begin
        period_ms        = PERIOD_RESET;
        prev_level       = 1'b0;
        ticks_since_beat = '0;
        oldest_slot      = '0;
        interval_sum     = '0;
        held_bpm         = '0;
        foreach (interval_hist[i]) interval_hist[i] = '0;
    end

    function automatic rate_result_t next_rate_result(bit level);
        rate_result_t res;
        int unsigned  interval;
        int unsigned  mean;
        if (ticks_since_beat != {TICK_W{1'b1}})
            ticks_since_beat++;
        res.beat_seen = 1'b0;
        if (level && !prev_level) begin
            interval = 32'(ticks_since_beat) * 32'(period_ms);
            if (interval > 65535)
                interval = 65535;
            interval_sum = interval_sum - interval_hist[oldest_slot] + TOTAL_W'(interval);
            interval_hist[oldest_slot] = INTERVAL_W'(interval);
            oldest_slot = (oldest_slot == HISTORY_DEPTH - 1) ? '0 : oldest_slot + 1'b1;
            mean = 32'(interval_sum) / HISTORY_DEPTH;
            // A mean of zero, early on or with a zero period, pins the rate at the top.
            held_bpm = (mean == 0) ? RATE_W'(RATE_NUMERATOR) : RATE_W'(RATE_NUMERATOR / mean);
            ticks_since_beat = '0;
            res.beat_seen = 1'b1;
        end
        prev_level = level;
        res.rate_bpm = held_bpm;
        return res;
    endfunction

    // Driver: the model advances on every accepted input beat.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                rate_expect_q.push_back(next_rate_result(s_tdata[0]));
            if (!s_tvalid || s_tready) begin
                if (tick_levels_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_DATA_W'(tick_levels_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor.
    always @(posedge aclk) begin
        rate_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (rate_expect_q.size() == 0) begin
                $error("unexpected result beat: rate_bpm %0d beat_seen %0b", m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                exp_res = rate_expect_q.pop_front();
                if (m_tdata !== exp_res.rate_bpm) begin
                    $error("rate_bpm: expected %0d, got %0d", exp_res.rate_bpm, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== exp_res.beat_seen) begin
                    $error("beat_seen: expected %0b, got %0b", exp_res.beat_seen, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** digital_pulse_rate_averager_core: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        while (tick_levels_q.size() != 0 || s_tvalid || rate_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_period(logic [PERIOD_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        period_ms    = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic push_run(bit level, int len);
        repeat (len) tick_levels_q.push_back(level);
    endtask

    // Mostly clean pulse trains with random gaps, with some noisy stretches mixed in.
    task automatic add_pulse_trains(int count);
        int added;
        int low_len;
        int high_len;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 99) < 85) begin
                low_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200)
                                                       : $urandom_range(1, 25);
                high_len = $urandom_range(1, 4);
                push_run(1'b0, low_len);
                push_run(1'b1, high_len);
                added += low_len + high_len;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    tick_levels_q.push_back(1'($urandom_range(0, 1)));
                    added++;
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 21;
        recv_idle_pct = 62;
        // Reset period: edge on the first tick, line held high, short gaps.
        tick_levels_q = '{1, 1, 1, 0, 1, 0, 0, 0, 1, 1, 0, 1, 0, 1};
        wait_drained();
        write_period(PERIOD_W'(1));
        add_pulse_trains(PHASE_TICKS);
        wait_drained();
        write_period(PERIOD_W'(1000));
        add_pulse_trains(PHASE_TICKS);
        wait_drained();

        // The other way round.
        send_idle_pct = 62;
        recv_idle_pct = 21;
        // A zero period yields zero intervals, so the rate goes to the top once the history holds only those.
        write_period('0);
        tick_levels_q = '{0, 1, 0, 1, 1, 0, 0, 1};
        add_pulse_trains(PHASE_TICKS);
        wait_drained();
        write_period({PERIOD_W{1'b1}});
        add_pulse_trains(PHASE_TICKS);
        wait_drained();

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_period(PERIOD_W'($urandom_range(1, 1000)));
        add_pulse_trains(PHASE_TICKS);
        wait_drained();
        write_period(PERIOD_W'($urandom_range(2, 999)));
        add_pulse_trains(PHASE_TICKS);
        wait_drained();

        if (mismatch_count == 0)
            $display("** digital_pulse_rate_averager_core: PASSED **");
        else
            $display("** digital_pulse_rate_averager_core: FAILED **");
        $finish;
    end

endmodule

[digital_pulse_rate_averager_core.f]
design/dpra_pkg.sv
design/dpra_front.sv
design/dpra_queue.sv
design/dpra_div.sv
design/dpra_back.sv
design/digital_pulse_rate_averager_core.sv
design/dpra_checker.sv
tb/tb.sv
